// File: sv/tts_pkg.sv
// Shared constants, codes, handshake structs and helpers for the tick timer scheduler.
package tts_pkg;

  localparam int SLOTS      = 16;
  localparam int DELAY_BITS = 16;
  localparam int IDX_W      = $clog2(SLOTS);
  localparam int CNT_W      = $clog2(SLOTS + 1);

  localparam logic [15:0] DELAY_MASK = 16'((17'd1 << DELAY_BITS) - 17'd1);

  localparam logic [1:0] OP_ONCE   = 2'd0;
  localparam logic [1:0] OP_REPEAT = 2'd1;
  localparam logic [1:0] OP_CANCEL = 2'd2;
  localparam logic [1:0] OP_TICK   = 2'd3;

  localparam logic [1:0] KIND_SCHEDULED = 2'd0;
  localparam logic [1:0] KIND_FIRED     = 2'd1;
  localparam logic [1:0] KIND_DONE      = 2'd2;
  localparam logic [1:0] KIND_FULL      = 2'd3;

  typedef struct packed {
    logic sched;
    logic cancel_start;
    logic tick_start;
    logic tick_step;
    logic cancel_step;
    logic tick_finish;
  } tts_cmd_t;

  typedef struct packed {
    logic scan_end;
    logic hit;
    logic fire;
    logic out_free;
  } tts_stat_t;

  // Keeps the low DELAY_BITS bits and lifts zero to one.
  function automatic logic [15:0] clamp_delay(input logic [15:0] v);
    logic [15:0] m;
    m = v & DELAY_MASK;
    return (m == 16'd0) ? 16'd1 : m;
  endfunction

endpackage

// File: sv/tts_ctrl.sv
// Control state machine of the tick timer scheduler.
module tts_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [1:0]         operation,
  input  tts_pkg::tts_stat_t stat,
  output tts_pkg::tts_cmd_t  cmd,
  output logic               in_stall
);
  import tts_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_CANCEL = 2'd1;
  localparam logic [1:0] ST_TICK   = 2'd2;
  localparam logic [1:0] ST_DONE   = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       accept;

  assign in_stall = (state != ST_IDLE) || !stat.out_free;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (operation inside {OP_ONCE, OP_REPEAT}) begin
            cmd.sched = 1'b1;
          end else if (operation == OP_CANCEL) begin
            cmd.cancel_start = 1'b1;
            state_next       = ST_CANCEL;
          end else begin
            cmd.tick_start = 1'b1;
            state_next     = ST_TICK;
          end
        end
      end
      ST_CANCEL: begin
        if (stat.scan_end) begin
          state_next = ST_IDLE;
        end else begin
          cmd.cancel_step = 1'b1;
          if (stat.hit) begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_TICK: begin
        if (stat.scan_end) begin
          state_next = ST_DONE;
        end else if (!(stat.fire && !stat.out_free)) begin
          cmd.tick_step = 1'b1;
        end
      end
      ST_DONE: begin
        if (stat.out_free) begin
          cmd.tick_finish = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: sv/tts_dpath.sv
// Datapath of the tick timer scheduler: timer table, counters and output register.
module tts_dpath (
  input  logic               clk,
  input  logic               rst,
  input  tts_pkg::tts_cmd_t  cmd,
  input  logic [1:0]         operation,
  input  logic [15:0]        first_delay,
  input  logic [15:0]        repeat_interval,
  input  logic [31:0]        target_handle,
  output tts_pkg::tts_stat_t stat,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         kind,
  output logic [31:0]        handle,
  output logic               last
);
  import tts_pkg::*;

  logic [31:0] slot_handle  [SLOTS];
  logic [31:0] slot_due     [SLOTS];
  logic [15:0] slot_period  [SLOTS];
  logic        slot_repeats [SLOTS];
  logic        slot_dead    [SLOTS];

  logic [31:0]      tick_count;
  logic [31:0]      next_handle;
  logic [CNT_W-1:0] entry_count;
  logic [CNT_W-1:0] scan_idx;
  logic [CNT_W-1:0] wr_idx;
  logic [31:0]      target;

  logic [IDX_W-1:0] rd;
  logic [31:0]      cur_handle;
  logic [31:0]      cur_due;
  logic [15:0]      cur_period;
  logic             cur_repeats;
  logic             cur_dead;
  logic [31:0]      lag;
  logic             fire;
  logic             keep;
  logic [31:0]      new_due;
  logic             full;
  logic             out_free;
  logic             sched_ok;
  logic             is_repeat;

  assign rd          = scan_idx[IDX_W-1:0];
  assign cur_handle  = slot_handle[rd];
  assign cur_due     = slot_due[rd];
  assign cur_period  = slot_period[rd];
  assign cur_repeats = slot_repeats[rd];
  assign cur_dead    = slot_dead[rd];

  // Wrap-safe due test: due when the tick count is not behind the due value.
  assign lag     = tick_count - cur_due;
  assign fire    = !cur_dead && !lag[31];
  assign keep    = !cur_dead && (!fire || cur_repeats);
  assign new_due = fire ? (cur_due + {16'd0, cur_period}) : cur_due;

  assign full      = (entry_count == CNT_W'(SLOTS));
  assign out_free  = !out_valid || !out_stall;
  assign sched_ok  = cmd.sched && !full;
  assign is_repeat = (operation == OP_REPEAT);

  assign stat.scan_end = (scan_idx == entry_count);
  assign stat.hit      = (cur_handle == target);
  assign stat.fire     = fire;
  assign stat.out_free = out_free;

  // Table writes: append, compacting rewrite, or cancel mark.
  always_ff @(posedge clk) begin
    if (sched_ok) begin
      slot_handle[entry_count[IDX_W-1:0]]  <= next_handle;
      slot_due[entry_count[IDX_W-1:0]]     <= tick_count + {16'd0, clamp_delay(first_delay)};
      slot_period[entry_count[IDX_W-1:0]]  <= is_repeat ? clamp_delay(repeat_interval) : 16'd0;
      slot_repeats[entry_count[IDX_W-1:0]] <= is_repeat;
      slot_dead[entry_count[IDX_W-1:0]]    <= 1'b0;
    end else if (cmd.tick_step && keep) begin
      slot_handle[wr_idx[IDX_W-1:0]]  <= cur_handle;
      slot_due[wr_idx[IDX_W-1:0]]     <= new_due;
      slot_period[wr_idx[IDX_W-1:0]]  <= cur_period;
      slot_repeats[wr_idx[IDX_W-1:0]] <= cur_repeats;
      slot_dead[wr_idx[IDX_W-1:0]]    <= 1'b0;
    end else if (cmd.cancel_step && stat.hit) begin
      slot_dead[rd] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count  <= '0;
      next_handle <= '0;
      entry_count <= '0;
      scan_idx    <= '0;
      wr_idx      <= '0;
    end else begin
      if (cmd.tick_start) begin
        tick_count <= tick_count + 32'd1;
      end
      if (sched_ok) begin
        next_handle <= next_handle + 32'd1;
        entry_count <= entry_count + CNT_W'(1);
      end else if (cmd.tick_finish) begin
        entry_count <= wr_idx;
      end
      if (cmd.tick_start || cmd.cancel_start) begin
        scan_idx <= '0;
      end else if (cmd.tick_step || cmd.cancel_step) begin
        scan_idx <= scan_idx + CNT_W'(1);
      end
      if (cmd.tick_start) begin
        wr_idx <= '0;
      end else if (cmd.tick_step && keep) begin
        wr_idx <= wr_idx + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cancel_start) begin
      target <= target_handle;
    end
  end

  // Output word register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.sched || (cmd.tick_step && fire) || cmd.tick_finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sched) begin
      kind   <= full ? KIND_FULL : KIND_SCHEDULED;
      handle <= full ? 32'd0 : next_handle;
      last   <= 1'b1;
    end else if (cmd.tick_step && fire) begin
      kind   <= KIND_FIRED;
      handle <= cur_handle;
      last   <= 1'b0;
    end else if (cmd.tick_finish) begin
      kind   <= KIND_DONE;
      handle <= 32'd0;
      last   <= 1'b1;
    end
  end

endmodule

// File: sv/tick_timer_scheduler.sv
// Top level of the tick timer scheduler: controller, datapath and checks.
// Latency: a schedule's result word is valid in the cycle after the word is accepted.
// A schedule leaves the controller idle; a cancel holds the input off while it scans the
// table, one entry per cycle, up to its target, and a tick while it scans the whole table.
// A full, stalled output register holds the input off and stalls a tick scan on a fired word.
// Synchronous active-high reset clears the counters, fill count and state, not the table.
module tick_timer_scheduler (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  operation,
  input  logic [15:0] first_delay,
  input  logic [15:0] repeat_interval,
  input  logic [31:0] target_handle,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [31:0] handle,
  output logic        last
);
  import tts_pkg::*;

  // The controller sequences the scans; the datapath owns the table, counters and output register and
  // reports back through a small status struct.
  tts_cmd_t  cmd;
  tts_stat_t stat;

  tts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .operation (operation),
    .stat      (stat),
    .cmd       (cmd),
    .in_stall  (in_stall)
  );

  // A tick walks the table once: due timers emit a fired word, survivors are
  // rewritten towards the front so the table stays compact and in creation order.
  tts_dpath u_dpath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .operation       (operation),
    .first_delay     (first_delay),
    .repeat_interval (repeat_interval),
    .target_handle   (target_handle),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .kind            (kind),
    .handle          (handle),
    .last            (last)
  );

`ifndef NO_ASSERTIONS
  // The done word closes a tick and carries no handle.
  a_done_word: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == KIND_DONE) |-> (last && handle == 32'd0))
    else $error("done word malformed");

  // Fired words are never the final word of a tick.
  a_fired_not_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == KIND_FIRED) |-> !last)
    else $error("fired word marked last");

  // A tick occupies the block for at least the following cycle.
  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && operation == OP_TICK) |=> in_stall)
    else $error("input accepted during tick scan");

  // A schedule request always yields a result word in the next cycle.
  a_sched_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && (operation == OP_ONCE || operation == OP_REPEAT))
      |=> (out_valid && last))
    else $error("schedule gave no result word");
`endif

endmodule
